>>> rtl/salc_pkg.sv
package salc_pkg;

    localparam int NUM_SETS       = 64;
    localparam int NUM_WAYS       = 4;
    localparam int WORDS_PER_LINE = 8;
    localparam int MEMORY_WORDS   = 16384;

    localparam int ADDR_W   = 14;
    localparam int OFF_W    = $clog2(WORDS_PER_LINE);
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int TAG_W    = ADDR_W - OFF_W - SET_W;
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int LINES    = NUM_SETS * NUM_WAYS;
    localparam int LINE_W   = $clog2(LINES);
    localparam int DATA_W   = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register byte addresses on the configuration port
    localparam logic [2:0] REG_ALLOC = 3'd0;
    localparam logic [2:0] REG_WBACK = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] store_word;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_word;
        logic              was_hit;
        logic              did_writeback;
        logic [DATA_W-1:0] total_hits;
    } rsp_t;

    // per-way set metadata as read from the tag memory
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] rank;
    } way_meta_t;

    typedef way_meta_t [NUM_WAYS-1:0] set_meta_t;

    // lookup decision passed from tag unit to the controller
    typedef struct packed {
        logic             hit;
        logic             has_free;
        logic [WAY_W-1:0] way;
    } lookup_t;

endpackage

>>> rtl/salc_tag_ram.sv
// Tag/state memory: one row per set holding all ways, plus per-set valid bits.
module salc_tag_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [salc_pkg::SET_W-1:0] rd_set,
    output salc_pkg::set_meta_t        rd_meta,
    input  logic                       wr_en,
    input  logic [salc_pkg::SET_W-1:0] wr_set,
    input  salc_pkg::set_meta_t        wr_meta
);

    salc_pkg::set_meta_t mem [salc_pkg::NUM_SETS];
    logic [salc_pkg::NUM_SETS-1:0] row_ok_reg;
    salc_pkg::set_meta_t rd_raw_reg;
    logic rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_meta;
        end
        rd_raw_reg <= mem[rd_set];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= row_ok_reg[rd_set];
            if (wr_en)
            begin
                row_ok_reg[wr_set] <= 1'b1;
            end
        end
    end

    // an unwritten row reads as all ways invalid, rank zero
    assign rd_meta = rd_ok_reg ? rd_raw_reg : '0;

endmodule

>>> rtl/salc_lookup.sv
module salc_lookup (
    input  salc_pkg::set_meta_t        meta,
    input  logic [salc_pkg::TAG_W-1:0] tag,
    output salc_pkg::lookup_t          res
);

    always_comb
    begin
        logic found_hit;
        logic found_free;
        logic [salc_pkg::WAY_W-1:0] best;
        logic [salc_pkg::WAY_W-1:0] hit_way;
        logic [salc_pkg::WAY_W-1:0] free_way;
        found_hit  = 1'b0;
        found_free = 1'b0;
        best       = '0;
        hit_way    = '0;
        free_way   = '0;
        res        = '0;
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++)
        begin
            if (!found_hit && meta[w].valid && meta[w].tag == tag)
            begin
                found_hit = 1'b1;
                hit_way   = w[salc_pkg::WAY_W-1:0];
            end
            if (!found_free && !meta[w].valid)
            begin
                found_free = 1'b1;
                free_way   = w[salc_pkg::WAY_W-1:0];
            end
        end
        // last way with the largest rank, as the ">=" scan picks
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++)
        begin
            if (meta[w].rank >= meta[best].rank)
            begin
                best = w[salc_pkg::WAY_W-1:0];
            end
        end
        res.hit      = found_hit;
        res.has_free = found_free;
        res.way      = found_hit ? hit_way : (found_free ? free_way : best);
    end

endmodule

>>> rtl/salc_ctrl.sv
// Sequencer: lookup, line writeback / fill word by word, word access, update.
module salc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  salc_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output salc_pkg::rsp_t out_data,
    input  logic           alloc_mode,
    input  logic           wb_mode
);

    localparam int LW_W  = salc_pkg::LINE_W + salc_pkg::OFF_W;
    localparam int CNT_W = salc_pkg::OFF_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_WB_RD, S_WB_WR, S_FILL_RD, S_FILL_WR,
        S_ACCESS, S_WT_RD, S_WT_WR, S_DONE
    } state_t;

    state_t state_reg;
    salc_pkg::req_t req_reg;
    salc_pkg::lookup_t lk_reg;
    salc_pkg::set_meta_t meta_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [salc_pkg::ADDR_W-1:0] clr_reg;
    logic [salc_pkg::DATA_W-1:0] hits_reg;
    logic wb_reg;
    logic out_valid_reg;
    salc_pkg::rsp_t out_reg;

    logic [salc_pkg::OFF_W-1:0] offset;
    logic [salc_pkg::SET_W-1:0] set_idx;
    logic [salc_pkg::TAG_W-1:0] tag;
    assign offset  = req_reg.word_address[salc_pkg::OFF_W-1:0];
    assign set_idx = req_reg.word_address[salc_pkg::OFF_W +: salc_pkg::SET_W];
    assign tag     = req_reg.word_address[salc_pkg::ADDR_W-1 -: salc_pkg::TAG_W];

    // the set row is read at the transfer edge so that it is ready for lookup
    logic [salc_pkg::SET_W-1:0] rd_set_idx;
    assign rd_set_idx = (state_reg == S_IDLE)
                        ? in_data.word_address[salc_pkg::OFF_W +: salc_pkg::SET_W]
                        : set_idx;

    salc_pkg::set_meta_t rd_meta;
    salc_pkg::lookup_t lk;
    logic tag_we;
    salc_pkg::set_meta_t tag_wdata;

    salc_tag_ram u_tag (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_set  (rd_set_idx),
        .rd_meta (rd_meta),
        .wr_en   (tag_we),
        .wr_set  (set_idx),
        .wr_meta (tag_wdata)
    );

    salc_lookup u_look (
        .meta (rd_meta),
        .tag  (tag),
        .res  (lk)
    );

    // line data memory and backing memory
    logic [salc_pkg::DATA_W-1:0] ldata [salc_pkg::LINES * salc_pkg::WORDS_PER_LINE];
    logic [salc_pkg::DATA_W-1:0] bmem [salc_pkg::MEMORY_WORDS];
    logic [salc_pkg::DATA_W-1:0] ld_q_reg;
    logic [salc_pkg::DATA_W-1:0] bm_q_reg;
    logic ld_we;
    logic [LW_W-1:0] ld_addr;
    logic [salc_pkg::DATA_W-1:0] ld_wd;
    logic bm_we;
    logic [salc_pkg::ADDR_W-1:0] bm_addr;
    logic [salc_pkg::DATA_W-1:0] bm_wd;

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            ldata[ld_addr] <= ld_wd;
        end
        ld_q_reg <= ldata[ld_addr];
        if (bm_we)
        begin
            bmem[bm_addr] <= bm_wd;
        end
        bm_q_reg <= bmem[bm_addr];
    end

    logic [salc_pkg::LINE_W-1:0] line;
    logic [salc_pkg::WAY_W-1:0] way;
    logic [salc_pkg::OFF_W-1:0] cw;
    assign way  = lk_reg.way;
    assign line = {set_idx, way};
    assign cw   = cnt_reg[salc_pkg::OFF_W-1:0];

    // memory port selection
    always_comb
    begin
        ld_we   = 1'b0;
        ld_addr = {line, offset};
        ld_wd   = req_reg.store_word;
        bm_we   = 1'b0;
        bm_addr = req_reg.word_address;
        bm_wd   = '0;
        unique case (state_reg) inside
            S_CLEAR:
            begin
                bm_we   = 1'b1;
                bm_addr = clr_reg;
            end
            S_WB_RD, S_WT_RD:
            begin
                ld_addr = {line, cw};
            end
            S_WB_WR:
            begin
                bm_we   = 1'b1;
                bm_addr = {meta_reg[way].tag, set_idx, cw};
                bm_wd   = ld_q_reg;
            end
            S_WT_WR:
            begin
                bm_we   = 1'b1;
                bm_addr = {tag, set_idx, cw};
                bm_wd   = ld_q_reg;
            end
            S_FILL_RD:
            begin
                bm_addr = {tag, set_idx, cw};
            end
            S_FILL_WR:
            begin
                ld_we   = 1'b1;
                ld_addr = {line, cw};
                ld_wd   = bm_q_reg;
            end
            S_ACCESS:
            begin
                if (!lk_reg.hit && req_reg.operation == salc_pkg::OP_WRITE && !alloc_mode)
                begin
                    bm_we = 1'b1;
                    bm_wd = req_reg.store_word;
                end
                else if (req_reg.operation == salc_pkg::OP_WRITE)
                begin
                    ld_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // metadata update at access time
    logic around;
    assign around = !lk_reg.hit && req_reg.operation == salc_pkg::OP_WRITE && !alloc_mode;

    always_comb
    begin
        logic [salc_pkg::WAY_W:0] old;
        tag_wdata = meta_reg;
        old = lk_reg.hit || !lk_reg.has_free ? {1'b0, meta_reg[way].rank}
                                             : (salc_pkg::WAY_W+1)'(salc_pkg::NUM_WAYS);
        for (int w = 0; w < salc_pkg::NUM_WAYS; w++)
        begin
            if (w[salc_pkg::WAY_W-1:0] != way && meta_reg[w].valid
                && {1'b0, meta_reg[w].rank} < old)
            begin
                tag_wdata[w].rank = meta_reg[w].rank + 1'b1;
            end
        end
        tag_wdata[way].rank  = '0;
        tag_wdata[way].valid = 1'b1;
        tag_wdata[way].tag   = tag;
        if (!lk_reg.hit)
        begin
            tag_wdata[way].dirty = 1'b0;
        end
        if (req_reg.operation == salc_pkg::OP_WRITE && wb_mode)
        begin
            tag_wdata[way].dirty = 1'b1;
        end
    end
    assign tag_we = (state_reg == S_ACCESS) && !around;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic last;
    assign last = (cnt_reg == CNT_W'(salc_pkg::WORDS_PER_LINE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            hits_reg      <= '0;
            wb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
            lk_reg        <= '0;
            meta_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == salc_pkg::ADDR_W'(salc_pkg::MEMORY_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    lk_reg   <= lk;
                    meta_reg <= rd_meta;
                    wb_reg   <= 1'b0;
                    cnt_reg  <= '0;
                    if (lk.hit)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                    if (lk.hit || (req_reg.operation == salc_pkg::OP_WRITE && !alloc_mode))
                    begin
                        state_reg <= S_ACCESS;
                    end
                    else if (!lk.has_free && rd_meta[lk.way].dirty)
                    begin
                        state_reg <= S_WB_RD;
                    end
                    else
                    begin
                        state_reg <= S_FILL_RD;
                    end
                end
                S_WB_RD:
                begin
                    state_reg <= S_WB_WR;
                end
                S_WB_WR:
                begin
                    wb_reg <= 1'b1;
                    if (last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FILL_RD;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_WB_RD;
                    end
                end
                S_FILL_RD:
                begin
                    state_reg <= S_FILL_WR;
                end
                S_FILL_WR:
                begin
                    if (last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_ACCESS;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_FILL_RD;
                    end
                end
                S_ACCESS:
                begin
                    cnt_reg <= '0;
                    if (req_reg.operation == salc_pkg::OP_WRITE && !wb_mode && !around)
                    begin
                        state_reg <= S_WT_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WT_RD:
                begin
                    state_reg <= S_WT_WR;
                end
                S_WT_WR:
                begin
                    if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_WT_RD;
                    end
                end
                S_DONE:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.read_word     <= (req_reg.operation == salc_pkg::OP_READ)
                                                 ? ld_q_reg : '0;
                        out_reg.was_hit       <= lk_reg.hit;
                        out_reg.did_writeback <= wb_reg;
                        out_reg.total_hits    <= hits_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/set_assoc_lru_cache_top.sv
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | req_t (operation, word_address, store_word)
// out     | output    | out_valid/stall  | rsp_t (read_word, was_hit, did_writeback, total_hits)
// cfg     | input     | APB psel/penable | write_allocate_mode, write_back_mode
// One item at a time: a hit or a write-around miss passes through the lookup, access and result
// states after the transfer.
// A miss adds a read and a write state per line word for the fill, and the same again when a
// dirty victim is written back; write-through adds them per word for the line copy, all set
// by the single-port memories. After reset the backing memory is cleared, one word a cycle, with
// in stalled. The result waits in an output register; the next item is taken once it is loaded.
module set_assoc_lru_cache_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  salc_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output salc_pkg::rsp_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic alloc_reg;
    logic wbm_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= 1'b1;
            wbm_reg   <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                salc_pkg::REG_ALLOC: alloc_reg <= pwdata[0];
                salc_pkg::REG_WBACK: wbm_reg   <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            salc_pkg::REG_ALLOC: prdata = {31'd0, alloc_reg};
            salc_pkg::REG_WBACK: prdata = {31'd0, wbm_reg};
            default:             prdata = '0;
        endcase
    end

    salc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .alloc_mode (alloc_reg),
        .wb_mode    (wbm_reg)
    );

endmodule

>>> tb/cache_checker.sv
module cache_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  salc_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  salc_pkg::rsp_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             fail_count,
    output int             pending
);

    localparam int LINES          = salc_pkg::LINES;
    localparam int TAG_W          = salc_pkg::TAG_W;
    localparam int WAY_W          = salc_pkg::WAY_W;
    localparam int DATA_W         = salc_pkg::DATA_W;
    localparam int ADDR_W         = salc_pkg::ADDR_W;
    localparam int OFF_W          = salc_pkg::OFF_W;
    localparam int SET_W          = salc_pkg::SET_W;
    localparam int NUM_SETS       = salc_pkg::NUM_SETS;
    localparam int NUM_WAYS       = salc_pkg::NUM_WAYS;
    localparam int WORDS_PER_LINE = salc_pkg::WORDS_PER_LINE;
    localparam int MEMORY_WORDS   = salc_pkg::MEMORY_WORDS;

    logic                  alloc_mode;
    logic                  wback_mode;
    logic                  valid_q  [LINES];
    logic                  dirty_q  [LINES];
    logic [TAG_W-1:0]      tag_q    [LINES];
    logic [WAY_W:0]        rank_q   [LINES];
    logic [DATA_W-1:0]     words_q  [LINES*WORDS_PER_LINE];
    logic [DATA_W-1:0]     mem_q    [MEMORY_WORDS];
    logic [DATA_W-1:0]     hits_q;
    salc_pkg::rsp_t        due_q[$];

    function automatic logic [ADDR_W-1:0] line_base(int ln, int set);
        return ADDR_W'((int'(tag_q[ln]) * NUM_SETS + set) * WORDS_PER_LINE);
    endfunction

    task automatic copy_out(int ln, int set);
        logic [ADDR_W-1:0] base;
        base = line_base(ln, set);
        for (int i = 0; i < WORDS_PER_LINE; i++)
            mem_q[ADDR_W'(base + i)] = words_q[ln*WORDS_PER_LINE + i];
    endtask

    task automatic access_cache(salc_pkg::req_t rq);
        salc_pkg::rsp_t r;
        int   off, set, first, way, best, ln, old;
        logic [TAG_W-1:0] tg;
        logic hit, found, is_wr;
        is_wr = (rq.operation == salc_pkg::OP_WRITE);
        off   = int'(rq.word_address[OFF_W-1:0]);
        set   = int'(rq.word_address[OFF_W +: SET_W]);
        tg    = rq.word_address[ADDR_W-1 -: TAG_W];
        first = set * NUM_WAYS;
        r     = '0;
        hit   = 1'b0;
        way   = 0;
        old   = NUM_WAYS;
        for (int w = 0; w < NUM_WAYS; w++)
            if (!hit && valid_q[first+w] && tag_q[first+w] == tg)
            begin
                hit = 1'b1;
                way = w;
            end
        if (hit)
            hits_q++;
        if (!hit && is_wr && !alloc_mode)
            mem_q[rq.word_address] = rq.store_word;
        else
        begin
            if (hit)
                old = int'(rank_q[first+way]);
            else
            begin
                found = 1'b0;
                for (int w = 0; w < NUM_WAYS; w++)
                    if (!found && !valid_q[first+w])
                    begin
                        way = w;
                        found = 1'b1;
                    end
                if (found)
                    old = NUM_WAYS;
                else
                begin
                    best = 0;
                    for (int w = 0; w < NUM_WAYS; w++)
                        if (int'(rank_q[first+w]) >= best)
                        begin
                            best = int'(rank_q[first+w]);
                            way = w;
                        end
                    old = int'(rank_q[first+way]);
                    if (dirty_q[first+way])
                    begin
                        copy_out(first+way, set);
                        r.did_writeback = 1'b1;
                    end
                end
                ln = first + way;
                tag_q[ln] = tg;
                for (int i = 0; i < WORDS_PER_LINE; i++)
                    words_q[ln*WORDS_PER_LINE+i] = mem_q[ADDR_W'(line_base(ln, set) + i)];
                dirty_q[ln] = 1'b0;
            end
            for (int w = 0; w < NUM_WAYS; w++)
                if (w != way && valid_q[first+w] && int'(rank_q[first+w]) < old)
                    rank_q[first+w]++;
            ln = first + way;
            rank_q[ln]  = '0;
            valid_q[ln] = 1'b1;
            if (is_wr)
            begin
                words_q[ln*WORDS_PER_LINE+off] = rq.store_word;
                if (wback_mode)
                    dirty_q[ln] = 1'b1;
                else
                    copy_out(ln, set);
            end
            else
                r.read_word = words_q[ln*WORDS_PER_LINE+off];
        end
        r.was_hit    = hit;
        r.total_hits = hits_q;
        due_q.push_back(r);
    endtask

    assign pending = due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_mode = 1'b1;
            wback_mode = 1'b1;
            hits_q     = '0;
            fail_count = 0;
            due_q.delete();
            for (int i = 0; i < LINES; i++)
            begin
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
                tag_q[i]   = '0;
                rank_q[i]  = '0;
            end
            foreach (words_q[i]) words_q[i] = '0;
            foreach (mem_q[i]) mem_q[i] = '0;
        end
        else
        begin
            // result first: a transfer out cannot belong to an item taken this edge
            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    salc_pkg::rsp_t e;
                    e = due_q.pop_front();
                    if (out_data.read_word !== e.read_word)
                    begin
                        $error("read_word exp %h got %h", e.read_word, out_data.read_word);
                        fail_count++;
                    end
                    if (out_data.was_hit !== e.was_hit)
                    begin
                        $error("was_hit exp %b got %b", e.was_hit, out_data.was_hit);
                        fail_count++;
                    end
                    if (out_data.did_writeback !== e.did_writeback)
                    begin
                        $error("did_writeback exp %b got %b", e.did_writeback,
                               out_data.did_writeback);
                        fail_count++;
                    end
                    if (out_data.total_hits !== e.total_hits)
                    begin
                        $error("total_hits exp %0d got %0d", e.total_hits, out_data.total_hits);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == salc_pkg::REG_ALLOC)
                    alloc_mode = pwdata[0];
                else if (paddr == salc_pkg::REG_WBACK)
                    wback_mode = pwdata[0];
            end
            if (in_valid && !in_stall)
                access_cache(in_data);
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;

    localparam int ADDR_W = salc_pkg::ADDR_W;
    localparam int DATA_W = salc_pkg::DATA_W;
    localparam int OFF_W  = salc_pkg::OFF_W;
    localparam int SET_W  = salc_pkg::SET_W;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    salc_pkg::req_t in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    salc_pkg::rsp_t out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    int             fail_count;
    int             pending;
    bit             hold_off = 1'b0;
    bit             choke = 1'b0;

    always #10 clk = ~clk;

    set_assoc_lru_cache_top uut (.*);

    cache_checker chk (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side stalls; long hold-off while choke is set
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (choke)
            begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                choke = 1'b0;
            end
            else if (hold_off)
                out_stall <= ($urandom_range(0, 99) < 35);
            else
                out_stall <= 1'b0;
        end
    end

    task automatic set_reg(logic [2:0] a, logic v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= {31'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays high after the transfer so that back-to-back items need no gap;
    // a later send with a gap, or drain, lowers it
    task automatic send(logic op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_data  <= '{operation: op, word_address: a, store_word: d};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // addresses mostly (eight in ten) confined to sets 0 to 3 so that evictions are frequent
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if ($urandom_range(0, 9) < 8)
            a[OFF_W +: SET_W] = SET_W'($urandom_range(0, 3));
        return a;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send(logic'($urandom_range(0, 1)), pick_addr(), $urandom, 1'b1);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, fill one set past its ways, dirty eviction, then write-around and write-through
        send(salc_pkg::OP_READ, '0, '0, 1'b0);
        send(salc_pkg::OP_WRITE, '0, '1, 1'b0);
        send(salc_pkg::OP_READ, '0, '0, 1'b0);
        send(salc_pkg::OP_WRITE, '1, 32'h8000_0001, 1'b0);
        send(salc_pkg::OP_READ, '1, '0, 1'b0);
        for (int t = 1; t < 6; t++)
            send(salc_pkg::OP_WRITE, ADDR_W'(t << (OFF_W + SET_W)), 32'h1111_0000 + t, 1'b0);
        send(salc_pkg::OP_READ, '0, '0, 1'b0);
        send(salc_pkg::OP_READ, ADDR_W'(1 << (OFF_W + SET_W)), '0, 1'b0);
        drain();
        set_reg(salc_pkg::REG_ALLOC, 1'b0);
        send(salc_pkg::OP_WRITE, 14'h2A55, 32'h5555_AAAA, 1'b0);
        send(salc_pkg::OP_READ, 14'h2A55, '0, 1'b0);
        send(salc_pkg::OP_WRITE, 14'h2A55, 32'hAAAA_5555, 1'b0);
        drain();
        set_reg(salc_pkg::REG_WBACK, 1'b0);
        send(salc_pkg::OP_WRITE, 14'h2A56, 32'h0F0F_F0F0, 1'b0);
        send(salc_pkg::OP_WRITE, 14'h3FF8, 32'h1234_5678, 1'b0);
        send(salc_pkg::OP_READ, 14'h3FF8, '0, 1'b0);
        drain();

        hold_off = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_reg(salc_pkg::REG_ALLOC, ph[0]);
            set_reg(salc_pkg::REG_WBACK, ph[1]);
            if (ph == 1)
                choke = 1'b1;
            random_phase(450);
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
